FILE: src/assert_macros.svh
// Assertion helper macros shared by the RTL of the matrix multiply block.
// Included by modules that carry concurrent checks; depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("same-cycle implication check failed");
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle implication check failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: src/mmb_pkg.sv
// Shared types and constants of the broadcast matrix multiply block.
// Used by mmb_mac and matrix_multiply_broadcast; depends on nothing.
package mmb_pkg;

	localparam int MAX_DIM   = 8;
	localparam int IDX_W     = $clog2(MAX_DIM);
	localparam int DIM_W     = 4;
	localparam int ELEM_W    = 16;
	localparam int PROD_W    = 2 * ELEM_W;
	localparam int ACC_W     = PROD_W + IDX_W + 1;
	localparam int ADDR_W    = 2 * IDX_W;
	localparam int CFG_IDX_W = 3;

	// Input modes.
	localparam logic [1:0] MODE_LOAD_LEFT  = 2'd0;
	localparam logic [1:0] MODE_LOAD_RIGHT = 2'd1;
	localparam logic [1:0] MODE_COMPUTE    = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_ROWS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_COLS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_ROWS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_COLS = 3'd3;

	// How the inner dimension is walked.
	localparam logic [1:0] KIND_PLAIN     = 2'd0;
	localparam logic [1:0] KIND_LEFT_COL  = 2'd1;
	localparam logic [1:0] KIND_RIGHT_ROW = 2'd2;

	typedef struct packed {
		logic [1:0]              mode;
		logic [IDX_W-1:0]        row_index;
		logic [IDX_W-1:0]        col_index;
		logic signed [ELEM_W-1:0] element;
	} in_beat_t;

	typedef struct packed {
		logic [IDX_W-1:0]         out_row;
		logic [IDX_W-1:0]         out_col;
		logic signed [PROD_W-1:0] product;
		logic                     shape_error;
		logic                     last;
	} out_beat_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_MAC   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

endpackage

FILE: src/mmb_mac.sv
// Shared multiply-accumulate unit: registered 16x16 product, wide accumulator
// and saturation to Q16.16. Depends on mmb_pkg.
module mmb_mac (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              clear,
	input  logic                              valid,
	input  logic signed [mmb_pkg::ELEM_W-1:0] a,
	input  logic signed [mmb_pkg::ELEM_W-1:0] b,
	output logic                              busy,
	output logic signed [mmb_pkg::PROD_W-1:0] sum_sat
);
	import mmb_pkg::*;

	localparam logic signed [ACC_W-1:0] SAT_MAX =
		ACC_W'(signed'({1'b0, {(PROD_W-1){1'b1}}}));
	localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

	logic signed [PROD_W-1:0] prod_s2;
	logic                     prod_valid_s2;
	logic signed [ACC_W-1:0]  acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_valid_s2 <= 1'b0;
		end else begin
			prod_valid_s2 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (valid) begin
			prod_s2 <= a * b;
		end
		if (clear) begin
			acc_q <= '0;
		end else if (prod_valid_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	assign busy = prod_valid_s2;

	always_comb begin
		if (acc_q > SAT_MAX) begin
			sum_sat = SAT_MAX[PROD_W-1:0];
		end else if (acc_q < SAT_MIN) begin
			sum_sat = SAT_MIN[PROD_W-1:0];
		end else begin
			sum_sat = acc_q[PROD_W-1:0];
		end
	end

endmodule

FILE: src/matrix_multiply_broadcast.sv
// Top level of the broadcast matrix multiply block: stores, sequencer, output
// register. Depends on mmb_pkg, mmb_mac and assert_macros.svh.
//
// Usage. Input beats arrive on in_valid/in_stall/in_data. A load beat (left or
// right) writes one Q8.8 element into its 64-entry store, and
// loads outside the configured shape are dropped. A compute beat runs the
// whole product and sends one output beat per element on out_valid/out_stall/
// out_data, row by row, with last set on the final element. When the shapes
// neither match nor broadcast, or a dimension register is out of range, a
// single beat with shape_error and last set is sent instead.
// A compute beat occupies the block for its whole run, which is set by the single
// shared multiply-accumulate unit doing one product per cycle during each element's
// inner steps, behind the registered store read; in_stall stays high for that whole
// run. Shape registers are written on cfg_we/cfg_index/cfg_data; the user must
// write them while idle only, as the block does not enforce it. Reset sets all
// dimensions to one and empties the output register; store contents are undefined
// until loaded. A stalled output holds its beat and the sequencer waits, so no beat
// is lost.
`include "assert_macros.svh"

module matrix_multiply_broadcast (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  mmb_pkg::in_beat_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output mmb_pkg::out_beat_t                out_data,
	input  logic                              cfg_we,
	input  logic [mmb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mmb_pkg::DIM_W-1:0]         cfg_data
);
	import mmb_pkg::*;

	localparam logic [DIM_W-1:0] DIM_ONE = DIM_W'(1);
	localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

	logic [DIM_W-1:0] left_rows_q, left_cols_q, right_rows_q, right_cols_q;

	state_t           state_q;
	logic [1:0]       kind_q;
	logic [DIM_W-1:0] inner_q;
	logic [IDX_W-1:0] i_q, j_q, k_q;
	logic             err_q;

	logic signed [ELEM_W-1:0] left_mem  [MAX_DIM*MAX_DIM];
	logic signed [ELEM_W-1:0] right_mem [MAX_DIM*MAX_DIM];
	logic signed [ELEM_W-1:0] left_rd_s1, right_rd_s1;
	logic                     rd_valid_s1;

	out_beat_t out_q;
	logic      out_valid_q;

	logic                     accept;
	logic                     load_left, load_right, start;
	logic                     dims_ok, shape_bad;
	logic [1:0]               kind_d;
	logic [DIM_W-1:0]         inner_d;
	logic [ADDR_W-1:0]        wr_addr, left_addr, right_addr;
	logic                     issue, last_k, last_elem, out_free, emit;
	logic                     mac_busy, mac_clear;
	logic signed [PROD_W-1:0] mac_sum;
	out_beat_t                out_d;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_rows_q  <= DIM_ONE;
			left_cols_q  <= DIM_ONE;
			right_rows_q <= DIM_ONE;
			right_cols_q <= DIM_ONE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LEFT_ROWS:  left_rows_q  <= cfg_data;
				REG_LEFT_COLS:  left_cols_q  <= cfg_data;
				REG_RIGHT_ROWS: right_rows_q <= cfg_data;
				REG_RIGHT_COLS: right_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input side: only the idle sequencer takes beats.
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// A load is kept only when it lands inside the configured shape.
	assign load_left  = accept && (in_data.mode == MODE_LOAD_LEFT)
		&& ({1'b0, in_data.row_index} < left_rows_q)
		&& ({1'b0, in_data.col_index} < left_cols_q);
	assign load_right = accept && (in_data.mode == MODE_LOAD_RIGHT)
		&& ({1'b0, in_data.row_index} < right_rows_q)
		&& ({1'b0, in_data.col_index} < right_cols_q);
	assign start      = accept && (in_data.mode == MODE_COMPUTE);
	assign wr_addr    = {in_data.row_index, in_data.col_index};

	// Shape decision for a compute beat.
	assign dims_ok = (left_rows_q  != '0) && (left_rows_q  <= DIM_MAX)
		&& (left_cols_q  != '0) && (left_cols_q  <= DIM_MAX)
		&& (right_rows_q != '0) && (right_rows_q <= DIM_MAX)
		&& (right_cols_q != '0) && (right_cols_q <= DIM_MAX);

	always_comb begin
		kind_d    = KIND_PLAIN;
		inner_d   = left_cols_q;
		shape_bad = 1'b0;
		priority if (!dims_ok) begin
			shape_bad = 1'b1;
		end else if (left_cols_q == right_rows_q) begin
			kind_d  = KIND_PLAIN;
			inner_d = left_cols_q;
		end else if (left_cols_q == DIM_ONE) begin
			// The single left column is reused for every inner step.
			kind_d  = KIND_LEFT_COL;
			inner_d = right_rows_q;
		end else if (right_rows_q == DIM_ONE) begin
			// The single right row is reused for every inner step.
			kind_d  = KIND_RIGHT_ROW;
			inner_d = left_cols_q;
		end else begin
			shape_bad = 1'b1;
		end
	end

	// Read addresses for the current inner step.
	assign issue      = (state_q == ST_MAC);
	assign left_addr  = {i_q, (kind_q == KIND_LEFT_COL) ? IDX_W'(0) : k_q};
	assign right_addr = {(kind_q == KIND_RIGHT_ROW) ? IDX_W'(0) : k_q, j_q};
	assign last_k     = ({1'b0, k_q} == inner_q - DIM_ONE);
	assign last_elem  = ({1'b0, i_q} == left_rows_q - DIM_ONE)
		&& ({1'b0, j_q} == right_cols_q - DIM_ONE);

	// Element stores: one write port used by loads, one registered read port.
	always_ff @(posedge clk) begin
		if (load_left) begin
			left_mem[wr_addr] <= in_data.element;
		end
		if (issue) begin
			left_rd_s1 <= left_mem[left_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (load_right) begin
			right_mem[wr_addr] <= in_data.element;
		end
		if (issue) begin
			right_rd_s1 <= right_mem[right_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
		end
	end

	// Clear the accumulator before each element's run.
	assign out_free  = !out_valid_q || !out_stall;
	assign emit      = (state_q == ST_EMIT) && out_free;
	assign mac_clear = start || emit;

	mmb_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (mac_clear),
		.valid   (rd_valid_s1),
		.a       (left_rd_s1),
		.b       (right_rd_s1),
		.busy    (mac_busy),
		.sum_sat (mac_sum)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= KIND_PLAIN;
			inner_q <= DIM_ONE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			err_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						kind_q  <= kind_d;
						inner_q <= inner_d;
						err_q   <= shape_bad;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= shape_bad ? ST_EMIT : ST_MAC;
					end
				end
				ST_MAC: begin
					if (last_k) begin
						k_q     <= '0;
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					// Wait for the read and multiply stages to land in the sum.
					if (!rd_valid_s1 && !mac_busy) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit) begin
						priority if (err_q || last_elem) begin
							state_q <= ST_IDLE;
						end else if ({1'b0, j_q} == right_cols_q - DIM_ONE) begin
							j_q     <= '0;
							i_q     <= i_q + IDX_W'(1);
							state_q <= ST_MAC;
						end else begin
							j_q     <= j_q + IDX_W'(1);
							state_q <= ST_MAC;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output beat and register.
	always_comb begin
		if (err_q) begin
			out_d.out_row     = '0;
			out_d.out_col     = '0;
			out_d.product     = '0;
			out_d.shape_error = 1'b1;
			out_d.last        = 1'b1;
		end else begin
			out_d.out_row     = i_q;
			out_d.out_col     = j_q;
			out_d.product     = mac_sum;
			out_d.shape_error = 1'b0;
			out_d.last        = last_elem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Checks on the sequencer and the multiply pipeline.
	`ASSERT_IMPL(a_emit_drained, clk, arst_n, state_q == ST_EMIT, !rd_valid_s1 && !mac_busy)
	`ASSERT_NEXT(a_last_ends_run, clk, arst_n, emit && out_d.last, state_q == ST_IDLE)
	`ASSERT_IMPL(a_error_is_last, clk, arst_n, out_valid_q, !out_q.shape_error || out_q.last)
	`ASSERT_IMPL(a_k_in_range, clk, arst_n, state_q == ST_MAC, {1'b0, k_q} < inner_q)

endmodule

FILE: tb/tb_matrix_multiply_broadcast.sv
`timescale 1ns / 100ps
// Testbench for matrix_multiply_broadcast: a directed step list, then random load and compute
// sequences, each product beat checked against a behavioral predictor held here.
// Depends on mmb_pkg and the matrix_multiply_broadcast RTL.
module tb_matrix_multiply_broadcast;
	import mmb_pkg::*;

	// The cycle limit assumes the slowest legal run. That is dozens of compute beats of up
	// to 64 products each, and a receiver that stalls half the time. All of that fits well
	// below this figure.
	localparam int LIMIT = 400000;
	// Quiet cycles after the last product before a shape write or the end of the run.
	localparam int SETTLE = 16;
	localparam int ITEMS_PER_PASS = 32;

	// Mode 3 is not decoded by the block.
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	// Register indexes that map to nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_FIRST = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LAST  = 3'd7;

	typedef enum logic {STEP_REG, STEP_BEAT} step_kind_t;

	// One row of the directed list: a register write or an input beat. Rows with typed set
	// carry their own expected product instead of asking the predictor.
	typedef struct {
		step_kind_t           kind;
		logic [CFG_IDX_W-1:0] reg_index;
		logic [DIM_W-1:0]     reg_value;
		in_beat_t             beat;
		bit                   typed;
		out_beat_t            typed_beat;
	} step_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_beat_t             in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_beat_t            out_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0]     cfg_data = '0;

	// Predictor state: the shape registers and both element stores. The loaded flags keep
	// the stimulus from ever computing over an entry that was never written. The shape array
	// spans the whole index range; only the four mapped entries are ever written or read.
	logic [DIM_W-1:0]         shape [2**CFG_IDX_W];
	logic signed [ELEM_W-1:0] left_elems [64];
	logic signed [ELEM_W-1:0] right_elems [64];
	bit                       left_loaded [64];
	bit                       right_loaded [64];

	out_beat_t expected_products [$];
	step_t     directed_steps [$];

	int errors = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_counted = 0;

	matrix_multiply_broadcast u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Watchdog: a hung handshake or a missing product ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("tb_matrix_multiply_broadcast failed");
			$finish;
		end
	end

	// The receiver stalls at random; the rate changes from pass to pass.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	task automatic report_mismatch(input string what, input out_beat_t got,
			input out_beat_t want);
		errors++;
		$display("%0t %s: got r%0d c%0d p=%h e%b l%b, want r%0d c%0d p=%h e%b l%b",
			$realtime, what, got.out_row, got.out_col, got.product, got.shape_error,
			got.last, want.out_row, want.out_col, want.product, want.shape_error, want.last);
	endtask

	// Each product beat taken by the receiver is compared with the oldest expectation.
	always @(posedge clk) begin : check_products
		out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_products.size() == 0) begin
				report_mismatch("product beat with nothing expected", out_data, '0);
			end else begin
				want = expected_products.pop_front();
				if (out_data.out_row !== want.out_row || out_data.out_col !== want.out_col ||
						out_data.product !== want.product ||
						out_data.shape_error !== want.shape_error ||
						out_data.last !== want.last) begin
					report_mismatch("product beat differs", out_data, want);
				end
			end
		end
	end

	function automatic bit dim_in_range(input logic [DIM_W-1:0] d);
		return d >= 1 && d <= MAX_DIM;
	endfunction

	// True when a compute beat would multiply, and so read every in-range store entry.
	// Otherwise it sends the single error beat.
	function automatic bit shapes_multiply();
		if (!dim_in_range(shape[REG_LEFT_ROWS]) || !dim_in_range(shape[REG_LEFT_COLS]) ||
				!dim_in_range(shape[REG_RIGHT_ROWS]) || !dim_in_range(shape[REG_RIGHT_COLS]))
			return 1'b0;
		return shape[REG_LEFT_COLS] == shape[REG_RIGHT_ROWS] ||
			shape[REG_LEFT_COLS] == 1 || shape[REG_RIGHT_ROWS] == 1;
	endfunction

	// A load is taken only when both indexes fall inside the loaded matrix.
	function automatic bit load_in_range(input in_beat_t b);
		case (b.mode)
			MODE_LOAD_LEFT: begin
				return b.row_index < shape[REG_LEFT_ROWS] && b.col_index < shape[REG_LEFT_COLS];
			end
			MODE_LOAD_RIGHT: begin
				return b.row_index < shape[REG_RIGHT_ROWS] &&
					b.col_index < shape[REG_RIGHT_COLS];
			end
			default: begin
				return 1'b0;
			end
		endcase
	endfunction

	function automatic logic signed [PROD_W-1:0] saturate_q16(input longint acc);
		if (acc > longint'(32'sh7FFF_FFFF))
			return 32'sh7FFF_FFFF;
		if (acc < -longint'(32'sh7FFF_FFFF) - 1)
			return 32'sh8000_0000;
		return acc[PROD_W-1:0];
	endfunction

	// Applies one accepted beat to the predictor state and queues the product beats it
	// causes, row by row.
	function automatic void compute_products(input in_beat_t b);
		int        addr;
		int        inner;
		int        lcol;
		int        rrow;
		logic [1:0] kind;
		longint    acc;
		out_beat_t res;
		addr = b.row_index * MAX_DIM + b.col_index;
		res = '0;
		case (b.mode)
			MODE_LOAD_LEFT: begin
				if (load_in_range(b)) begin
					left_elems[addr] = b.element;
					left_loaded[addr] = 1'b1;
				end
			end
			MODE_LOAD_RIGHT: begin
				if (load_in_range(b)) begin
					right_elems[addr] = b.element;
					right_loaded[addr] = 1'b1;
				end
			end
			MODE_COMPUTE: begin
				if (!shapes_multiply()) begin
					res.shape_error = 1'b1;
					res.last = 1'b1;
					expected_products = {expected_products, res};
				end else begin
					// Matching shapes win over either broadcast.
					if (shape[REG_LEFT_COLS] == shape[REG_RIGHT_ROWS]) begin
						kind = KIND_PLAIN;
						inner = shape[REG_LEFT_COLS];
					end else if (shape[REG_LEFT_COLS] == 1) begin
						kind = KIND_LEFT_COL;
						inner = shape[REG_RIGHT_ROWS];
					end else begin
						kind = KIND_RIGHT_ROW;
						inner = shape[REG_LEFT_COLS];
					end
					for (int i = 0; i < shape[REG_LEFT_ROWS]; i++) begin
						for (int j = 0; j < shape[REG_RIGHT_COLS]; j++) begin
							acc = 0;
							for (int k = 0; k < inner; k++) begin
								lcol = (kind == KIND_LEFT_COL) ? 0 : k;
								rrow = (kind == KIND_RIGHT_ROW) ? 0 : k;
								acc += longint'(left_elems[i * MAX_DIM + lcol]) *
									longint'(right_elems[rrow * MAX_DIM + j]);
							end
							res.out_row = IDX_W'(i);
							res.out_col = IDX_W'(j);
							res.product = saturate_q16(acc);
							res.shape_error = 1'b0;
							res.last = (i == shape[REG_LEFT_ROWS] - 1) &&
								(j == shape[REG_RIGHT_COLS] - 1);
							expected_products = {expected_products, res};
						end
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	// Sends one beat. The caller stands at a falling edge, and the task returns at one
	// with valid still high. Each falling edge sees a single assignment to valid.
	task automatic send_beat(input in_beat_t b, input bit typed, input out_beat_t typed_beat);
		int depth;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_counted++;
		depth = expected_products.size();
		compute_products(b);
		if (typed) begin
			while (expected_products.size() > depth)
				void'(expected_products.pop_back());
			expected_products = {expected_products, typed_beat};
		end
		@(negedge clk);
	endtask

	// Lowers valid, then waits for every expected product and a quiet settle period.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_products.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx <= REG_RIGHT_COLS)
			shape[idx] = value;
	endtask

	function automatic void put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] v);
		step_t s;
		s = '{kind: STEP_REG, default: '0};
		s.kind = STEP_REG;
		s.reg_index = idx;
		s.reg_value = v;
		directed_steps = {directed_steps, s};
	endfunction

	function automatic void put_beat(input logic [1:0] m, input int r, input int c, input int e);
		step_t s;
		s = '{kind: STEP_BEAT, default: '0};
		s.kind = STEP_BEAT;
		s.beat.mode = m;
		s.beat.row_index = IDX_W'(r);
		s.beat.col_index = IDX_W'(c);
		s.beat.element = ELEM_W'(e);
		directed_steps = {directed_steps, s};
	endfunction

	// A compute beat whose single product beat is written out by hand.
	function automatic void put_typed(input logic signed [PROD_W-1:0] p, input bit err);
		step_t s;
		s = '{kind: STEP_BEAT, default: '0};
		s.kind = STEP_BEAT;
		s.beat.mode = MODE_COMPUTE;
		s.typed = 1'b1;
		s.typed_beat.product = p;
		s.typed_beat.shape_error = err;
		s.typed_beat.last = 1'b1;
		directed_steps = {directed_steps, s};
	endfunction

	// Mostly small sizes, with the full eight now and then.
	function automatic logic [DIM_W-1:0] pick_dim();
		return ($urandom_range(0, 11) == 0) ? DIM_W'(MAX_DIM) : DIM_W'($urandom_range(1, 3));
	endfunction

	function automatic logic [ELEM_W-1:0] pick_element();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return ELEM_W'($urandom);
		endcase
	endfunction

	// One random sequence. It writes a shape and sends a few loose loads and undecoded
	// beats. It then loads every entry that the product would read and that is still
	// unwritten, and ends with one or two compute beats.
	task automatic run_random_sequence();
		logic [DIM_W-1:0] dims [2**CFG_IDX_W];
		logic [DIM_W-1:0] lim;
		in_beat_t         b;
		int               pick;
		pick = $urandom_range(0, 9);
		dims[REG_LEFT_ROWS] = pick_dim();
		dims[REG_RIGHT_COLS] = pick_dim();
		if (pick <= 3) begin
			dims[REG_LEFT_COLS] = pick_dim();
			dims[REG_RIGHT_ROWS] = dims[REG_LEFT_COLS];
		end else if (pick <= 5) begin
			dims[REG_LEFT_COLS] = 1;
			dims[REG_RIGHT_ROWS] = pick_dim();
		end else if (pick <= 7) begin
			dims[REG_RIGHT_ROWS] = 1;
			dims[REG_LEFT_COLS] = pick_dim();
		end else if (pick == 8) begin
			// Usually neither shapes match nor a broadcast applies.
			dims[REG_LEFT_COLS] = DIM_W'($urandom_range(2, MAX_DIM));
			dims[REG_RIGHT_ROWS] = DIM_W'($urandom_range(2, MAX_DIM));
		end else begin
			// One register is zero or above the largest size.
			dims[REG_LEFT_COLS] = pick_dim();
			dims[REG_RIGHT_ROWS] = dims[REG_LEFT_COLS];
			dims[$urandom_range(0, 3)] = $urandom_range(0, 1) ? '0 :
				DIM_W'($urandom_range(MAX_DIM + 1, 15));
		end
		write_reg(REG_LEFT_ROWS, dims[REG_LEFT_ROWS]);
		write_reg(REG_LEFT_COLS, dims[REG_LEFT_COLS]);
		write_reg(REG_RIGHT_ROWS, dims[REG_RIGHT_ROWS]);
		write_reg(REG_RIGHT_COLS, dims[REG_RIGHT_COLS]);
		if ($urandom_range(0, 7) == 0)
			write_reg(CFG_IDX_W'($urandom_range(REG_UNMAPPED_FIRST, REG_UNMAPPED_LAST)),
				DIM_W'($urandom));

		repeat ($urandom_range(0, 4)) begin
			b.mode = $urandom_range(0, 1) ? MODE_LOAD_RIGHT : MODE_LOAD_LEFT;
			b.element = pick_element();
			b.row_index = IDX_W'($urandom);
			b.col_index = IDX_W'($urandom);
			// Half of the loose loads are aimed inside the matrix.
			if ($urandom_range(0, 1)) begin
				lim = (b.mode == MODE_LOAD_LEFT) ? shape[REG_LEFT_ROWS] : shape[REG_RIGHT_ROWS];
				if (lim > MAX_DIM)
					lim = MAX_DIM;
				if (lim != 0)
					b.row_index = IDX_W'($urandom_range(0, lim - 1));
				lim = (b.mode == MODE_LOAD_LEFT) ? shape[REG_LEFT_COLS] : shape[REG_RIGHT_COLS];
				if (lim > MAX_DIM)
					lim = MAX_DIM;
				if (lim != 0)
					b.col_index = IDX_W'($urandom_range(0, lim - 1));
			end
			if ($urandom_range(0, 5) == 0)
				b.mode = MODE_UNUSED;
			send_beat(b, 1'b0, '0);
		end

		if (shapes_multiply()) begin
			for (int i = 0; i < shape[REG_LEFT_ROWS]; i++) begin
				for (int j = 0; j < shape[REG_LEFT_COLS]; j++) begin
					if (!left_loaded[i * MAX_DIM + j]) begin
						b.mode = MODE_LOAD_LEFT;
						b.row_index = IDX_W'(i);
						b.col_index = IDX_W'(j);
						b.element = pick_element();
						send_beat(b, 1'b0, '0);
					end
				end
			end
			for (int i = 0; i < shape[REG_RIGHT_ROWS]; i++) begin
				for (int j = 0; j < shape[REG_RIGHT_COLS]; j++) begin
					if (!right_loaded[i * MAX_DIM + j]) begin
						b.mode = MODE_LOAD_RIGHT;
						b.row_index = IDX_W'(i);
						b.col_index = IDX_W'(j);
						b.element = pick_element();
						send_beat(b, 1'b0, '0);
					end
				end
			end
		end

		// The index and element fields of a compute beat carry no meaning.
		repeat ($urandom_range(0, 3) == 0 ? 2 : 1) begin
			b.mode = MODE_COMPUTE;
			b.row_index = IDX_W'($urandom);
			b.col_index = IDX_W'($urandom);
			b.element = ELEM_W'($urandom);
			send_beat(b, 1'b0, '0);
		end
		wait_drained();
	endtask

	initial begin
		for (int i = 0; i < 4; i++)
			shape[i] = 1;
		for (int i = 0; i < 64; i++) begin
			left_elems[i] = '0;
			right_elems[i] = '0;
			left_loaded[i] = 1'b0;
			right_loaded[i] = 1'b0;
		end

		// Directed list. After reset every matrix is one by one. The most negative element
		// squared gives exactly 0x40000000.
		put_beat(MODE_LOAD_LEFT, 0, 0, -32768);
		put_beat(MODE_LOAD_RIGHT, 0, 0, -32768);
		put_typed(32'sh4000_0000, 1'b0);
		// An undecoded mode and loads outside the shape must not touch the stores.
		put_beat(MODE_UNUSED, 0, 0, 32767);
		put_beat(MODE_LOAD_LEFT, 1, 0, 32767);
		put_beat(MODE_LOAD_RIGHT, 7, 7, 32767);
		put_typed(32'sh4000_0000, 1'b0);
		// Inner size three with the most negative and the most positive elements gives a sum
		// below the 32-bit range. The sum is clamped to the minimum.
		put_reg(REG_LEFT_COLS, 3);
		put_reg(REG_RIGHT_ROWS, 3);
		put_beat(MODE_LOAD_LEFT, 0, 1, -32768);
		put_beat(MODE_LOAD_LEFT, 0, 2, -32768);
		put_beat(MODE_LOAD_RIGHT, 0, 0, 32767);
		put_beat(MODE_LOAD_RIGHT, 1, 0, 32767);
		put_beat(MODE_LOAD_RIGHT, 2, 0, 32767);
		put_typed(32'sh8000_0000, 1'b0);
		// All most negative: three times 2^30 is clamped to the maximum.
		put_beat(MODE_LOAD_RIGHT, 0, 0, -32768);
		put_beat(MODE_LOAD_RIGHT, 1, 0, -32768);
		put_beat(MODE_LOAD_RIGHT, 2, 0, -32768);
		put_typed(32'sh7FFF_FFFF, 1'b0);
		// Inner sizes two and three, and neither is one: the error beat.
		put_reg(REG_LEFT_COLS, 2);
		put_typed(32'sh0, 1'b1);
		// A one-column left matrix is repeated across the three right rows.
		put_reg(REG_LEFT_COLS, 1);
		put_beat(MODE_COMPUTE, 0, 0, 0);
		// Writes to unmapped indexes are dropped. The one-row right matrix is then repeated
		// down the three left columns.
		put_reg(REG_UNMAPPED_FIRST, 0);
		put_reg(REG_UNMAPPED_LAST, 15);
		put_reg(REG_LEFT_COLS, 3);
		put_reg(REG_RIGHT_ROWS, 1);
		put_beat(MODE_COMPUTE, 7, 7, -1);
		// Sizes of zero and above eight both give the error beat.
		put_reg(REG_LEFT_ROWS, 0);
		put_typed(32'sh0, 1'b1);
		put_reg(REG_LEFT_ROWS, 1);
		put_reg(REG_RIGHT_COLS, 9);
		put_typed(32'sh0, 1'b1);

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 6;
		recv_stall_pct = 46;
		foreach (directed_steps[i]) begin
			if (directed_steps[i].kind == STEP_REG) begin
				wait_drained();
				write_reg(directed_steps[i].reg_index, directed_steps[i].reg_value);
			end else begin
				send_beat(directed_steps[i].beat, directed_steps[i].typed,
					directed_steps[i].typed_beat);
			end
		end
		wait_drained();

		// Random passes: a sender that idles rarely against a receiver that stalls often,
		// then the reverse, then both at full rate.
		for (int pass = 0; pass < 3; pass++) begin
			send_idle_pct = (pass == 0) ? 6 : (pass == 1) ? 46 : 0;
			recv_stall_pct = (pass == 0) ? 46 : (pass == 1) ? 6 : 0;
			items_counted = 0;
			while (items_counted < ITEMS_PER_PASS)
				run_random_sequence();
		end

		wait_drained();
		if (errors == 0)
			$display("tb_matrix_multiply_broadcast passed");
		else
			$display("tb_matrix_multiply_broadcast failed");
		$finish;
	end

endmodule
